FILE: src/arp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_pkg
// shared constants and types of the modem reply parser
// ----------------------------------------------------------------------------
package arp_pkg;

	// depth of the information line buffer
	localparam int LINE_DEPTH = 64;
	localparam int WPOS_W     = $clog2(LINE_DEPTH + 1);
	localparam int PHASE_W    = 4;
	localparam int LINES_W    = 16;
	localparam int LEN_W      = 7;
	localparam int STATUS_W   = 2;

	// characters
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_O     = 8'h4F;
	localparam logic [7:0] CH_K     = 8'h4B;
	localparam logic [7:0] CH_E     = 8'h45;
	localparam logic [7:0] CH_R     = 8'h52;

	// parser phases
	localparam logic [PHASE_W-1:0] PH_WAIT_CR    = 4'd0;
	localparam logic [PHASE_W-1:0] PH_WAIT_LF    = 4'd1;
	localparam logic [PHASE_W-1:0] PH_FIRST      = 4'd2;
	localparam logic [PHASE_W-1:0] PH_COLLECT    = 4'd3;
	localparam logic [PHASE_W-1:0] PH_INFO_LF    = 4'd4;
	localparam logic [PHASE_W-1:0] PH_AFTER_INFO = 4'd5;
	localparam logic [PHASE_W-1:0] PH_BLANK_LF   = 4'd6;
	localparam logic [PHASE_W-1:0] PH_FINAL_WORD = 4'd7;
	localparam logic [PHASE_W-1:0] PH_OK_K       = 4'd8;
	localparam logic [PHASE_W-1:0] PH_ERR_R1     = 4'd9;
	localparam logic [PHASE_W-1:0] PH_ERR_R2     = 4'd10;
	localparam logic [PHASE_W-1:0] PH_ERR_O      = 4'd11;
	localparam logic [PHASE_W-1:0] PH_ERR_R3     = 4'd12;
	localparam logic [PHASE_W-1:0] PH_END_CR     = 4'd13;
	localparam logic [PHASE_W-1:0] PH_END_LF     = 4'd14;

	// per-byte status codes
	localparam logic [STATUS_W-1:0] ST_ACCEPT     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_UNEXPECTED = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL       = 2'd2;

	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic [WPOS_W-1:0]  wpos;
		logic [LINES_W-1:0] lines;
		logic               ok;
	} parse_state_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                done;
	} step_flags_t;

endpackage

FILE: src/arp_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_step
// next-state and status logic for one received byte
// ----------------------------------------------------------------------------
module arp_step
	import arp_pkg::*;
(
	input  logic [7:0]   rx_byte,
	input  parse_state_t cur,
	output parse_state_t nxt,
	output step_flags_t  flags
);

	logic [LINES_W-1:0] lines_inc;

	assign lines_inc = cur.lines + LINES_W'(1);

	always_comb begin
		nxt          = cur;
		flags.status = ST_UNEXPECTED;
		flags.done   = 1'b0;
		case (cur.phase)
			PH_WAIT_CR: begin
				if (rx_byte == CH_CR) begin
					nxt.phase    = PH_WAIT_LF;
					flags.status = ST_ACCEPT;
				end
			end
			PH_WAIT_LF: begin
				if (rx_byte inside {CH_LF, CH_CR}) begin
					nxt.phase    = PH_FIRST;
					flags.status = ST_ACCEPT;
				end
			end
			PH_FIRST, PH_FINAL_WORD: begin
				if (rx_byte == CH_PLUS && cur.phase == PH_FIRST) begin
					nxt.phase    = PH_COLLECT;
					nxt.lines    = lines_inc;
					flags.status = ST_ACCEPT;
				end else if (rx_byte == CH_O) begin
					nxt.phase    = PH_OK_K;
					flags.status = ST_ACCEPT;
				end else if (rx_byte == CH_E) begin
					nxt.phase    = PH_ERR_R1;
					flags.status = ST_ACCEPT;
				end
			end
			PH_COLLECT: begin
				if (rx_byte == CH_CR) begin
					nxt.phase    = PH_INFO_LF;
					nxt.wpos     = '0;
					nxt.lines    = lines_inc;
					flags.status = ST_ACCEPT;
				end else if (cur.wpos < WPOS_W'(LINE_DEPTH)) begin
					// byte goes to the line buffer, only its count is visible
					nxt.wpos     = cur.wpos + WPOS_W'(1);
					flags.status = ST_ACCEPT;
				end else begin
					flags.status = ST_FULL;
				end
			end
			PH_INFO_LF: begin
				if (rx_byte == CH_LF) begin
					nxt.phase    = PH_AFTER_INFO;
					flags.status = ST_ACCEPT;
				end
			end
			PH_AFTER_INFO: begin
				if (rx_byte == CH_PLUS) begin
					nxt.phase    = PH_COLLECT;
					nxt.lines    = lines_inc;
					flags.status = ST_ACCEPT;
				end else if (rx_byte == CH_CR) begin
					nxt.phase    = PH_BLANK_LF;
					flags.status = ST_ACCEPT;
				end
			end
			PH_BLANK_LF: begin
				if (rx_byte == CH_LF) begin
					nxt.phase    = PH_FINAL_WORD;
					flags.status = ST_ACCEPT;
				end
			end
			PH_OK_K: begin
				if (rx_byte == CH_K) begin
					nxt.phase    = PH_END_CR;
					nxt.ok       = 1'b1;
					flags.status = ST_ACCEPT;
				end
			end
			PH_ERR_R1: begin
				if (rx_byte == CH_R) begin
					nxt.phase    = PH_ERR_R2;
					flags.status = ST_ACCEPT;
				end
			end
			PH_ERR_R2: begin
				if (rx_byte == CH_R) begin
					nxt.phase    = PH_ERR_O;
					flags.status = ST_ACCEPT;
				end
			end
			PH_ERR_O: begin
				if (rx_byte == CH_O) begin
					nxt.phase    = PH_ERR_R3;
					flags.status = ST_ACCEPT;
				end
			end
			PH_ERR_R3: begin
				if (rx_byte == CH_R) begin
					nxt.phase    = PH_END_CR;
					nxt.ok       = 1'b0;
					flags.status = ST_ACCEPT;
				end
			end
			PH_END_CR: begin
				if (rx_byte == CH_CR) begin
					nxt.phase    = PH_END_LF;
					flags.status = ST_ACCEPT;
				end
			end
			PH_END_LF: begin
				if (rx_byte == CH_LF) begin
					nxt.phase    = PH_WAIT_CR;
					flags.done   = 1'b1;
					flags.status = ST_ACCEPT;
				end else if (rx_byte == CH_CR) begin
					flags.status = ST_ACCEPT;
				end
			end
			default: begin
				nxt.phase = PH_WAIT_CR;
			end
		endcase
	end

endmodule

FILE: src/at_response_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// at_response_parser_unit
// byte-serial parser of modem replies, one status request per received byte
// ----------------------------------------------------------------------------
//
// channel   dir  signals                      request contents
// s_*       in   s_tvalid s_tready s_tdata    rx_byte
// m_*       out  m_tvalid m_tready m_tdata    status, reply_ok, lines_seen,
//                m_tlast                      line_length; tlast = reply_done
//
// one byte per cycle sustained while m_tready does not stall; a byte passes the
// input register, then the result register, on its way to the status request on m_*
// the parser state advances in the same cycle that the result register loads
// arst_n clears the parser to waiting for the first CR, line counter to one
// a stall on m_tready freezes both stages; s_tready drops only when the input
// register is full and the result register cannot move
//
module at_response_parser_unit
	import arp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// input bytes
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	// status requests
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [1:0] status, [2] reply_ok, [18:3] lines_seen,
	                               // [25:19] line_length, [31:26] zero
	output logic        m_tlast    // reply_done
);

	// input register
	logic         valid_s1;
	logic [7:0]   byte_s1;

	// parser state
	parse_state_t st_q;
	parse_state_t st_nxt;
	step_flags_t  flags;

	// result register
	logic                valid_s2;
	logic [STATUS_W-1:0] status_s2;
	logic                done_s2;
	logic                ok_s2;
	logic [LINES_W-1:0]  lines_s2;
	logic [LEN_W-1:0]    len_s2;

	logic advance;
	logic fire;

	// result register can take a new request when empty or being drained
	assign advance  = !valid_s2 || m_tready;
	assign fire     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	arp_step u_step (
		.rx_byte (byte_s1),
		.cur     (st_q),
		.nxt     (st_nxt),
		.flags   (flags)
	);

	// state commits only when the byte's result is loaded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase <= PH_WAIT_CR;
			st_q.wpos  <= '0;
			st_q.lines <= LINES_W'(1);
			st_q.ok    <= 1'b0;
		end else if (fire) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_s2 <= flags.status;
			done_s2   <= flags.done;
			ok_s2     <= st_nxt.ok;
			lines_s2  <= st_nxt.lines;
			// write position, the same width as line_length
			len_s2    <= LEN_W'(st_nxt.wpos);
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tlast  = done_s2;
	assign m_tdata  = {6'd0, len_s2, lines_s2, ok_s2, status_s2};

	// status code three is never produced
	a_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (status_s2 != 2'd3))
		else $error("illegal status code");

	// a completed reply is always an accepted byte
	a_done_accepted: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (status_s2 == ST_ACCEPT))
		else $error("reply done with non-accept status");

	// write position never passes the buffer depth
	a_wpos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.wpos <= WPOS_W'(LINE_DEPTH))
		else $error("write position beyond line buffer");

	// line counter steps by at most one per processed byte
	a_lines_step: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> (st_q.lines == $past(st_q.lines)) ||
			(st_q.lines == $past(st_q.lines) + LINES_W'(1)))
		else $error("line counter jumped");

	// state holds while no byte is processed
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(st_q))
		else $error("parser state moved without a byte");

endmodule

FILE: verif/at_response_parser_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// at_response_parser_unit_tb
// self-checking bench for the modem reply parser: a byte driver and a status
// monitor around the unit, with a byte-level model of the reply framing.
// every accepted byte queues its predicted status request, and every request
// leaving the unit is compared field by field with the oldest prediction.
// stimulus is a short hand-built pair of replies, then random well-formed
// replies with noise and abandoned replies, under four idling phases.
// ----------------------------------------------------------------------------
module at_response_parser_unit_tb;
	import arp_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 8;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                done;
		logic                ok;
		logic [LINES_W-1:0]  lines;
		logic [LEN_W-1:0]    len;
	} byte_status_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;   // [7:0] rx_byte
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;          // [1:0] status, [2] reply_ok, [18:3] lines_seen,
	                               // [25:19] line_length, [31:26] zero
	logic        m_tlast;          // reply_done

	// framing model state
	logic [PHASE_W-1:0] frame_phase = PH_WAIT_CR;
	logic [WPOS_W-1:0]  fill_pos = '0;
	logic [LINES_W-1:0] model_lines = 16'd1;
	logic               last_ok = 1'b0;

	logic [7:0]   rx_pending[$];
	byte_status_t status_due[$];
	int           bytes_queued = 0;
	int           bytes_in = 0;
	int           requests_out = 0;
	int           errors = 0;
	int           cycle_count = 0;
	int           send_idle_pct = 0;
	int           recv_stall_pct = 0;
	int           noise_pct = 0;
	bit           want_hold = 1'b0;
	bit           hold_taken = 1'b0;
	int           hold_left = 0;
	logic         byte_taken = 1'b0;

	at_response_parser_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// advances the framing model by one byte and returns its status request
	function automatic byte_status_t parse_byte(input logic [7:0] rx);
		byte_status_t res;
		res.status = ST_UNEXPECTED;
		res.done = 1'b0;
		case (frame_phase)
			PH_WAIT_CR: begin
				if (rx == CH_CR) begin
					frame_phase = PH_WAIT_LF;
					res.status = ST_ACCEPT;
				end
			end
			PH_WAIT_LF: begin
				if (rx == CH_LF || rx == CH_CR) begin
					frame_phase = PH_FIRST;
					res.status = ST_ACCEPT;
				end
			end
			PH_FIRST, PH_FINAL_WORD: begin
				// '+' opens an information line only before any blank line
				if (rx == CH_PLUS && frame_phase == PH_FIRST) begin
					frame_phase = PH_COLLECT;
					model_lines++;
					res.status = ST_ACCEPT;
				end else if (rx == CH_O) begin
					frame_phase = PH_OK_K;
					res.status = ST_ACCEPT;
				end else if (rx == CH_E) begin
					frame_phase = PH_ERR_R1;
					res.status = ST_ACCEPT;
				end
			end
			PH_COLLECT: begin
				if (rx == CH_CR) begin
					frame_phase = PH_INFO_LF;
					fill_pos = '0;
					model_lines++;
					res.status = ST_ACCEPT;
				end else if (fill_pos < LINE_DEPTH) begin
					fill_pos++;
					res.status = ST_ACCEPT;
				end else begin
					res.status = ST_FULL;
				end
			end
			PH_INFO_LF: begin
				if (rx == CH_LF) begin
					frame_phase = PH_AFTER_INFO;
					res.status = ST_ACCEPT;
				end
			end
			PH_AFTER_INFO: begin
				if (rx == CH_PLUS) begin
					frame_phase = PH_COLLECT;
					model_lines++;
					res.status = ST_ACCEPT;
				end else if (rx == CH_CR) begin
					frame_phase = PH_BLANK_LF;
					res.status = ST_ACCEPT;
				end
			end
			PH_BLANK_LF: begin
				if (rx == CH_LF) begin
					frame_phase = PH_FINAL_WORD;
					res.status = ST_ACCEPT;
				end
			end
			PH_OK_K: begin
				if (rx == CH_K) begin
					frame_phase = PH_END_CR;
					last_ok = 1'b1;
					res.status = ST_ACCEPT;
				end
			end
			PH_ERR_R1: begin
				if (rx == CH_R) begin
					frame_phase = PH_ERR_R2;
					res.status = ST_ACCEPT;
				end
			end
			PH_ERR_R2: begin
				if (rx == CH_R) begin
					frame_phase = PH_ERR_O;
					res.status = ST_ACCEPT;
				end
			end
			PH_ERR_O: begin
				if (rx == CH_O) begin
					frame_phase = PH_ERR_R3;
					res.status = ST_ACCEPT;
				end
			end
			PH_ERR_R3: begin
				if (rx == CH_R) begin
					frame_phase = PH_END_CR;
					last_ok = 1'b0;
					res.status = ST_ACCEPT;
				end
			end
			PH_END_CR: begin
				if (rx == CH_CR) begin
					frame_phase = PH_END_LF;
					res.status = ST_ACCEPT;
				end
			end
			PH_END_LF: begin
				// extra CRs before the final LF are tolerated
				if (rx == CH_LF) begin
					frame_phase = PH_WAIT_CR;
					res.done = 1'b1;
					res.status = ST_ACCEPT;
				end else if (rx == CH_CR) begin
					res.status = ST_ACCEPT;
				end
			end
			default: begin
				frame_phase = PH_WAIT_CR;
			end
		endcase
		res.ok = last_ok;
		res.lines = model_lines;
		res.len = LEN_W'(fill_pos);
		return res;
	endfunction

	task automatic flag_mismatch(input string what, input longint got, input longint want);
		$display("mismatch on %s at request %0d: got 0x%0h, expected 0x%0h",
			what, requests_out, got, want);
		errors++;
	endtask

	// queues one byte, sometimes behind a stray noise byte
	task automatic put_byte(input logic [7:0] b);
		if ($urandom_range(99) < noise_pct) begin
			rx_pending.push_back(8'($urandom_range(255)));
			bytes_queued++;
		end
		rx_pending.push_back(b);
		bytes_queued++;
	endtask

	// one reply with random content; force_long fills or overruns the line buffer
	task automatic add_reply(input bit force_long);
		int n_info;
		int len;
		logic [7:0] ch;
		put_byte(CH_CR);
		put_byte($urandom_range(1) ? CH_LF : CH_CR);
		n_info = $urandom_range(3);
		if (force_long && n_info == 0)
			n_info = 1;
		for (int i = 0; i < n_info; i++) begin
			put_byte(CH_PLUS);
			if (force_long && i == 0)
				len = $urandom_range(LINE_DEPTH + 6, LINE_DEPTH);
			else if ($urandom_range(19) == 0)
				len = $urandom_range(LINE_DEPTH + 6, LINE_DEPTH - 4);
			else
				len = $urandom_range(8);
			for (int j = 0; j < len; j++) begin
				ch = 8'($urandom_range(255));
				// a CR would end the line early
				if (ch == CH_CR)
					ch = 8'h20;
				put_byte(ch);
			end
			put_byte(CH_CR);
			put_byte(CH_LF);
		end
		// blank line is mandatory after information lines, optional otherwise
		if (n_info != 0 || $urandom_range(3) == 0) begin
			put_byte(CH_CR);
			put_byte(CH_LF);
		end
		// abandoned reply, the next one starts in the middle of the framing
		if ($urandom_range(11) == 0)
			return;
		if ($urandom_range(1)) begin
			put_byte(CH_O);
			put_byte(CH_K);
		end else begin
			put_byte(CH_E);
			put_byte(CH_R);
			put_byte(CH_R);
			put_byte(CH_O);
			put_byte(CH_R);
		end
		put_byte(CH_CR);
		if ($urandom_range(3) == 0)
			put_byte(CH_CR);
		put_byte(CH_LF);
	endtask

	// byte driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || byte_taken) begin
				if (rx_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					s_tdata <= rx_pending.pop_front();
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// request sink, with one long hold-off to back the unit up
	always @(negedge clk) begin
		if (arst_n) begin
			if (want_hold && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// monitor: check leaving requests first, then predict the accepted byte
	always @(posedge clk) begin
		byte_status_t want;
		byte_taken <= s_tvalid && s_tready;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (status_due.size() == 0) begin
					flag_mismatch("request with none pending", m_tdata, 0);
				end else begin
					want = status_due.pop_front();
					if (m_tdata[1:0] != want.status)
						flag_mismatch("status", m_tdata[1:0], want.status);
					if (m_tdata[2] != want.ok)
						flag_mismatch("reply_ok", m_tdata[2], want.ok);
					if (m_tdata[18:3] != want.lines)
						flag_mismatch("lines_seen", m_tdata[18:3], want.lines);
					if (m_tdata[25:19] != want.len)
						flag_mismatch("line_length", m_tdata[25:19], want.len);
					if (m_tdata[31:26] != 6'd0)
						flag_mismatch("pad bits", m_tdata[31:26], 0);
					if (m_tlast != want.done)
						flag_mismatch("reply_done", m_tlast, want.done);
				end
				requests_out <= requests_out + 1;
			end
			if (s_tvalid && s_tready) begin
				status_due.push_back(parse_byte(s_tdata));
				bytes_in <= bytes_in + 1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic wait_drained();
		while (rx_pending.size() != 0 || bytes_in != bytes_queued)
			@(posedge clk);
	endtask

	initial begin
		// directed: two complete replies through every phase
		noise_pct = 0;
		put_byte(8'hFF);   // unexpected while waiting for the first CR
		put_byte(CH_CR);
		put_byte(CH_CR);   // CR accepted in place of LF
		put_byte(CH_PLUS);
		put_byte(8'h00);
		put_byte(8'hFF);
		put_byte(8'h41);
		put_byte(CH_CR);
		put_byte(8'h58);   // unexpected, waiting for LF
		put_byte(CH_LF);
		put_byte(CH_PLUS);
		put_byte(CH_CR);   // empty information line
		put_byte(CH_LF);
		put_byte(CH_CR);
		put_byte(CH_LF);
		put_byte(CH_O);
		put_byte(CH_K);
		put_byte(CH_CR);
		put_byte(CH_CR);   // repeated CR before final LF
		put_byte(CH_LF);
		put_byte(CH_CR);
		put_byte(CH_LF);
		put_byte(CH_E);
		put_byte(CH_R);
		put_byte(CH_R);
		put_byte(CH_O);
		put_byte(CH_R);
		put_byte(CH_CR);
		put_byte(CH_LF);

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait_drained();

		// no idling, one long receiver hold so the input side stalls
		noise_pct = 3;
		add_reply(1'b1);
		while (bytes_queued < 190)
			add_reply(1'b0);
		want_hold = 1'b1;
		wait_drained();

		// sender mostly idle
		send_idle_pct = 84;
		while (bytes_queued < 350)
			add_reply(1'b0);
		wait_drained();

		// receiver mostly stalling
		send_idle_pct = 0;
		recv_stall_pct = 84;
		while (bytes_queued < 510)
			add_reply(1'b0);
		wait_drained();

		// both sides idle now and then
		send_idle_pct = 12;
		recv_stall_pct = 12;
		add_reply(1'b1);
		while (bytes_queued < 680)
			add_reply(1'b0);
		wait_drained();

		while (status_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

FILE: filelist.f
src/arp_pkg.sv
src/arp_step.sv
src/at_response_parser_unit.sv
verif/at_response_parser_unit_tb.sv
